FILE: src/glw_pkg.sv
// shared types, constants and helpers for the greedy line wrapper
`default_nettype none

package glw_pkg;

    localparam int LEN_W           = 6;
    localparam int MAX_WIDTH_DEF   = 62;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] DEFAULT_WIDTH = 6'd25;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_FLUSH,
        CMD_CHUNK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] width;
    } glw_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PRE_NL,
        BK_BYTES,
        BK_SUFFIX
    } back_state_t;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {CH_SP, [8'h09:8'h0D]};
    endfunction

endpackage

`default_nettype wire

FILE: src/glw_if.sv
// valid/ready channel interfaces for text input and wrapped output
`default_nettype none

interface glw_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface glw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: src/glw_front.sv
// front end: width register, word tracking and command classification
`default_nettype none

module glw_front
    import glw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    glw_in_if.sink                text,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    input  wire logic             q_full,
    output logic                  q_push,
    output glw_cmd_t              q_cmd
);

    logic [LEN_W-1:0] width_reg;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic [LEN_W-1:0] act_width_reg;
    logic [LEN_W-1:0] clamped;
    logic [LEN_W-1:0] eff_width;
    logic             accept;
    logic             separator;

    assign text.ready = !q_full;
    assign accept     = text.valid && !q_full;
    assign separator  = text.kind || is_space(text.text_byte);

    always_comb
    begin
        if (width_reg == '0)
            clamped = LEN_W'(1);
        else if (width_reg > LEN_W'(MAX_WIDTH))
            clamped = LEN_W'(MAX_WIDTH);
        else
            clamped = width_reg;
    end

    // width is only picked up when no word is pending
    assign eff_width = (word_len_reg == '0) ? clamped : act_width_reg;

    always_comb
    begin
        q_cmd.op      = CMD_APPEND;
        q_cmd.data    = text.text_byte;
        q_cmd.len     = word_len_reg;
        q_cmd.width   = eff_width;
        q_push        = 1'b0;
        word_len_next = word_len_reg;
        if (accept)
        begin
            if (separator)
            begin
                if (word_len_reg != '0)
                begin
                    q_cmd.op      = CMD_FLUSH;
                    q_push        = 1'b1;
                    word_len_next = '0;
                end
            end
            else if (word_len_reg >= eff_width)
            begin
                q_cmd.op      = CMD_CHUNK;
                q_push        = 1'b1;
                word_len_next = LEN_W'(1);
            end
            else
            begin
                q_cmd.op      = CMD_APPEND;
                q_push        = 1'b1;
                word_len_next = word_len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DEFAULT_WIDTH;
            word_len_reg  <= '0;
            act_width_reg <= DEFAULT_WIDTH;
        end
        else
        begin
            if (cfg_we)
                width_reg <= cfg_wdata;
            word_len_reg <= word_len_next;
            if (accept)
                act_width_reg <= eff_width;
        end
    end

endmodule

`default_nettype wire

FILE: src/glw_cmd_queue.sv
// small command queue between front and back
`default_nettype none

module glw_cmd_queue
    import glw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire glw_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output glw_cmd_t      pop_cmd,
    output logic          empty
);

    glw_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

FILE: src/glw_back.sv
// back end: word buffer, line column tracking and byte emission
`default_nettype none

module glw_back
    import glw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  wire glw_cmd_t q_cmd,
    output logic          q_pop,
    glw_out_if.source     wrapped
);

    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [7:0]       word_mem [MAX_WIDTH];
    logic [7:0]       rd_data_reg;

    back_state_t      state_reg, state_next;
    glw_cmd_t         cmd_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] cols_reg, cols_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             can_emit;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [LEN_W:0]   idx_p1;
    logic [LEN_W:0]   cols_plus_len;
    logic             need_nl;

    assign can_emit      = !out_valid_reg || wrapped.ready;
    assign idx_p1        = {1'b0, idx_reg} + (LEN_W+1)'(1);
    assign cols_plus_len = {1'b0, cols_reg} + {1'b0, cmd_reg.len};

    // leading newline for the command at the queue head
    always_comb
    begin
        if (q_cmd.op == CMD_CHUNK)
            need_nl = (cols_reg != '0);
        else
            need_nl = (cols_reg != '0) &&
                      (({1'b0, cols_reg} + {1'b0, q_cmd.len}) > {1'b0, q_cmd.width});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && (q_cmd.op != CMD_APPEND))
                    state_next = need_nl ? BK_PRE_NL : BK_BYTES;
            end
            BK_PRE_NL:
            begin
                if (can_emit)
                    state_next = BK_BYTES;
            end
            BK_BYTES:
            begin
                if (can_emit && (idx_p1 == {1'b0, cmd_reg.len}))
                    state_next = BK_SUFFIX;
            end
            BK_SUFFIX:
            begin
                if (can_emit)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_byte = CH_NL;
        emit_last = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = q_cmd.len[IDX_W-1:0];
        wr_data   = q_cmd.data;
        rd_addr   = '0;
        idx_next  = idx_reg;
        cols_next = cols_reg;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.op == CMD_APPEND)
                        wr_en = 1'b1;
                end
            end
            BK_PRE_NL:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    cols_next = '0;
                end
            end
            BK_BYTES:
            begin
                if (can_emit && (idx_p1 < {1'b0, cmd_reg.len}))
                    rd_addr = idx_p1[IDX_W-1:0];
                else
                    rd_addr = idx_reg[IDX_W-1:0];
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = rd_data_reg;
                    idx_next  = idx_p1[LEN_W-1:0];
                end
            end
            BK_SUFFIX:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if ((cmd_reg.op == CMD_FLUSH) &&
                        (cols_plus_len < {1'b0, cmd_reg.width}))
                    begin
                        emit_byte = CH_SP;
                        cols_next = cols_plus_len[LEN_W-1:0] + LEN_W'(1);
                    end
                    else
                    begin
                        cols_next = '0;
                    end
                    // a cut word restarts its buffer with the byte that overflowed
                    if (cmd_reg.op == CMD_CHUNK)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = cmd_reg.data;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            word_mem[wr_addr] <= wr_data;
        rd_data_reg <= word_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            cols_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cols_reg  <= cols_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (wrapped.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign wrapped.valid    = out_valid_reg;
    assign wrapped.out_byte = out_byte_reg;
    assign wrapped.last     = out_last_reg;

endmodule

`default_nettype wire

FILE: src/greedy_line_wrapper.sv
// greedy line wrapper top level: front end, command queue and emitting back end
// each word byte takes one queue slot; a word's flush or cut command passes through
//   the queue and the back-end command register before the registered output stage
// throughput: one input transfer per cycle while the queue has room; output bytes go out
//   one per cycle while the sink takes them: newline if needed, word, space or newline
// reset: rst_n clears all control state asynchronously, line width returns to 25
`default_nettype none

module greedy_line_wrapper
    import glw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    glw_in_if.sink                text,
    glw_out_if.source             wrapped,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata
);

    // command handoff between front and back
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    glw_cmd_t q_push_cmd;
    glw_cmd_t q_pop_cmd;

    // front end: holds the width register, tracks the pending word length, turns
    // word bytes and word-ending separators into append, flush or chunk commands
    glw_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // short queue so text keeps flowing while a word is still going out
    glw_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // back end: owns the word buffer and the column count, emits bytes through
    // a registered output stage that frees up whenever the sink takes a transfer
    glw_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_pop_cmd),
        .q_pop   (q_pop),
        .wrapped (wrapped)
    );

`ifndef ASSERT_OFF
    // the back end never pops a command that is not there
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // every queued width is a clamped, legal line width
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_push_cmd.width != '0) && (q_push_cmd.width <= LEN_W'(MAX_WIDTH)))
        else $error("command carries an out of range width");

    // appends stay inside the width, flushes and chunks carry a nonempty word
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((q_push_cmd.op == CMD_APPEND) && (q_push_cmd.len < q_push_cmd.width)) ||
                   ((q_push_cmd.op != CMD_APPEND) && (q_push_cmd.len != '0) &&
                    (q_push_cmd.len <= q_push_cmd.width)))
        else $error("command word length inconsistent with its width");
`endif

endmodule

`default_nettype wire

FILE: bench/greedy_line_wrapper_tb.sv
// self-checking testbench for the greedy line wrapper with a built-in wrap predictor
`timescale 1ns / 100ps

module greedy_line_wrapper_tb;
    import glw_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int SETTLE      = 10;    // cycles after the last result before a config write
    localparam int QUIET_LIMIT = 3000;  // cycles without any transfer before giving up
    localparam int LONG_HOLD   = 300;   // receiver hold-off long enough to back up the input
    localparam int PHASE_ITEMS = 30;    // random text transfers per width setting
    localparam int PHASES      = 8;

    // one output transfer as the predictor expects it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } wrapped_beat_t;

    // greedy wrap predictor plus the queue of output transfers it still expects
    class wrap_scoreboard;
        logic [7:0]      word_buf [MAX_WIDTH_DEF];
        int unsigned     word_len;
        int unsigned     line_cols;
        logic [LEN_W-1:0] width_reg;
        int unsigned     width_live;
        wrapped_beat_t   expected_q [$];
        int unsigned     errors;

        function new();
            word_len   = 0;
            line_cols  = 0;
            width_reg  = DEFAULT_WIDTH;
            width_live = clamp(DEFAULT_WIDTH);
            errors     = 0;
        endfunction

        static function bit is_blank(input logic [7:0] b);
            case (b)
                8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SP: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        static function int unsigned clamp(input logic [LEN_W-1:0] w);
            if (w == '0)
                return 1;
            if (w > MAX_WIDTH_DEF)
                return MAX_WIDTH_DEF;
            return w;
        endfunction

        function void set_width(input logic [LEN_W-1:0] w);
            width_reg = w;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function void emit(input logic [7:0] b);
            wrapped_beat_t beat;
            beat.out_byte = b;
            beat.last     = 1'b0;
            expected_q.push_back(beat);
        endfunction

        function void emit_word();
            for (int unsigned i = 0; i < word_len; i++)
                emit(word_buf[i]);
        endfunction

        function void flush_word();
            if (word_len == 0)
                return;
            if (line_cols != 0 && line_cols + word_len > width_live)
            begin
                emit(CH_NL);
                line_cols = 0;
            end
            emit_word();
            if (line_cols + word_len < width_live)
            begin
                emit(CH_SP);
                line_cols = line_cols + word_len + 1;
            end
            else
            begin
                emit(CH_NL);
                line_cols = 0;
            end
            word_len = 0;
        endfunction

        // an accepted input transfer: queue up every output it causes
        function void note_text(input logic kind, input logic [7:0] b);
            int unsigned   before_n;
            wrapped_beat_t tail;
            before_n = expected_q.size();
            if (word_len == 0)
                width_live = clamp(width_reg);
            if (kind || is_blank(b))
                flush_word();
            else
            begin
                if (word_len >= width_live)
                begin
                    if (line_cols != 0)
                        emit(CH_NL);
                    emit_word();
                    emit(CH_NL);
                    line_cols = 0;
                    word_len  = 0;
                end
                if (word_len < MAX_WIDTH_DEF)
                begin
                    word_buf[word_len] = b;
                    word_len++;
                end
            end
            if (expected_q.size() > before_n)
            begin
                tail      = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.push_back(tail);
            end
        endfunction

        // an accepted output transfer against the oldest expectation
        function void check_wrapped(input logic [7:0] ob, input logic lst);
            wrapped_beat_t exp_beat;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output transfer: out_byte=%h last=%b", ob, lst);
                errors++;
                return;
            end
            exp_beat = expected_q.pop_front();
            if (ob !== exp_beat.out_byte)
            begin
                $error("out_byte mismatch: expected %h, actual %h", exp_beat.out_byte, ob);
                errors++;
            end
            if (lst !== exp_beat.last)
            begin
                $error("last mismatch: expected %b, actual %b", exp_beat.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    glw_in_if  text_ch ();
    glw_out_if wrapped_ch ();

    wrap_scoreboard sb = new();

    // shared knobs between the sender and the receiver, plus the watchdog count
    bit calm          = 1'b0;  // no idling on either side while set
    int long_hold_req = 0;     // receiver picks this up and stalls that many cycles
    int quiet_cycles  = 0;

    logic [7:0] blanks [6] = '{CH_SP, 8'h09, CH_NL, 8'h0B, 8'h0C, 8'h0D};

    greedy_line_wrapper DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .wrapped   (wrapped_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // any byte that is not whitespace, so it always extends the current word
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (wrap_scoreboard::is_blank(c));
        return c;
    endfunction

    // offer one item, possibly after a random gap, and wait for its transfer;
    // valid is left high so back-to-back items need no second assignment per edge
    task automatic send_text(input logic kind, input logic [7:0] b);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.kind      <= kind;
        text_ch.text_byte <= b;
        do
            @(posedge clk);
        while (!text_ch.ready);
        sb.note_text(kind, b);
    endtask

    task automatic send_word(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_text(1'b0, word_char());
    endtask

    // stop offering, wait for every expected output, then let the block settle;
    // a pending word produces no output, so the settle cycles cover its last byte
    task automatic drain_output(input int settle);
        text_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_width(input logic [LEN_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        sb.set_width(w);
        cfg_we <= 1'b0;
    endtask

    // receiver: check each output transfer, then pick ready for the next cycle
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wrapped_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (wrapped_ch.valid && wrapped_ch.ready)
                sb.check_wrapped(wrapped_ch.out_byte, wrapped_ch.last);
            if (long_hold_req > 0)
            begin
                stall_left    = long_hold_req;
                long_hold_req = 0;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                stall_left--;
                wrapped_ch.ready <= 1'b0;
            end
            else
                wrapped_ch.ready <= 1'b1;
        end
    end

    // watchdog: a long run of cycles with no transfer on either side means a hang
    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (wrapped_ch.valid && wrapped_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("greedy_line_wrapper test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0] phase_width [PHASES];
        logic [LEN_W-1:0] w;
        int unsigned      eff;
        int unsigned      len;
        int               sent;
        int               r;
        bit               paused;

        phase_width = '{6'd1, 6'd62, 6'd0, 6'd63, 6'd7, 6'd25, 6'd3, 6'd12};
        paused      = 1'b0;

        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.kind      <= 1'b0;
        text_ch.text_byte <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default width: word made of the bytes just outside the whitespace range
        // and the byte extremes, ended by a tab
        send_text(1'b0, 8'h00);
        send_text(1'b0, 8'hFF);
        send_text(1'b0, 8'h08);
        send_text(1'b0, 8'h0E);
        send_text(1'b0, 8'h09);
        // whitespace and end of text with no word pending: no output at all
        send_text(1'b0, CH_NL);
        send_text(1'b1, 8'h41);
        send_text(1'b0, 8'h1F);
        send_text(1'b0, 8'h21);
        send_text(1'b0, 8'h7F);
        // a run of the other whitespace bytes, the first one flushes
        send_text(1'b0, 8'h0B);
        send_text(1'b0, 8'h0C);
        send_text(1'b0, 8'h0D);
        send_text(1'b0, CH_SP);
        // end of text flushes the word; its byte field is a space and is ignored
        send_text(1'b0, 8'h80);
        send_text(1'b1, CH_SP);
        drain_output(SETTLE);

        // width 0 acts as 1: every further word byte forces a chunk out
        write_width(6'd0);
        send_text(1'b0, 8'h41);
        send_text(1'b0, 8'h42);
        send_text(1'b0, 8'h43);
        send_text(1'b1, 8'hBE);
        drain_output(SETTLE);

        // width 63 acts as 62; the width then drops to 2 while a word is open,
        // and that word still wraps at 62
        write_width(6'd63);
        send_text(1'b0, 8'h78);
        send_text(1'b0, 8'h79);
        drain_output(SETTLE);
        write_width(6'd2);
        send_text(1'b0, 8'h7A);
        send_text(1'b0, CH_SP);
        // next word sees width 2: new line, then it ends exactly at the width
        send_text(1'b0, 8'h70);
        send_text(1'b0, 8'h71);
        send_text(1'b0, CH_SP);
        drain_output(SETTLE);

        // random text: mostly words of random bytes split by whitespace, some
        // words past the width, some end-of-text items and some raw noise
        for (int phase = 0; phase < PHASES; phase++)
        begin
            w   = (phase < 4) ? phase_width[phase] : 6'($urandom_range(0, 63));
            eff = wrap_scoreboard::clamp(w);
            write_width(w);
            calm = (phase == 4) || (phase == PHASES - 1);
            // width 1 makes nearly every byte a chunk, so the queue backs up fast
            if (phase == 2)
                long_hold_req = LONG_HOLD;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r >= 95)
                begin
                    send_text(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    sent++;
                end
                else
                begin
                    if (r < 10)
                        len = $urandom_range(eff, 2 * eff + 1);
                    else
                        len = $urandom_range(1, (eff < 9) ? eff : 9);
                    send_word(len);
                    sent += len;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_text(1'b1, 8'($urandom_range(0, 255)));
                        sent++;
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 2))
                        begin
                            send_text(1'b0, blanks[$urandom_range(0, 5)]);
                            sent++;
                        end
                    end
                end
                // the sender sits out once until the output side has caught up
                if (phase == 5 && sent > PHASE_ITEMS / 2 && !paused)
                begin
                    paused = 1'b1;
                    drain_output(0);
                end
            end
            drain_output(SETTLE);
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("greedy_line_wrapper test passed");
        else
            $display("greedy_line_wrapper test failed");
        $finish;
    end

endmodule

FILE: files.f
src/glw_pkg.sv
src/glw_if.sv
src/glw_front.sv
src/glw_cmd_queue.sv
src/glw_back.sv
src/greedy_line_wrapper.sv
bench/greedy_line_wrapper_tb.sv
